// File: rtl/core/scru_pkg.sv
// Package for the stack call/return unit: operation codes, decode types and constants.
package scru_pkg;

    localparam logic [4:0] FUNC_RET_NZ  = 5'd0;
    localparam logic [4:0] FUNC_POP_BC  = 5'd1;
    localparam logic [4:0] FUNC_CALL_NZ = 5'd2;
    localparam logic [4:0] FUNC_PUSH_BC = 5'd3;
    localparam logic [4:0] FUNC_CALL_Z  = 5'd4;
    localparam logic [4:0] FUNC_RET_Z   = 5'd5;
    localparam logic [4:0] FUNC_RET     = 5'd6;
    localparam logic [4:0] FUNC_CALL    = 5'd7;
    localparam logic [4:0] FUNC_RET_NC  = 5'd8;
    localparam logic [4:0] FUNC_POP_DE  = 5'd9;
    localparam logic [4:0] FUNC_CALL_NC = 5'd10;
    localparam logic [4:0] FUNC_PUSH_DE = 5'd11;
    localparam logic [4:0] FUNC_RET_C   = 5'd12;
    localparam logic [4:0] FUNC_RETI    = 5'd13;
    localparam logic [4:0] FUNC_CALL_C  = 5'd14;
    localparam logic [4:0] FUNC_POP_HL  = 5'd15;
    localparam logic [4:0] FUNC_PUSH_HL = 5'd16;
    localparam logic [4:0] FUNC_POP_AF  = 5'd17;
    localparam logic [4:0] FUNC_PUSH_AF = 5'd18;

    localparam logic [4:0] CYC_NONE    = 5'd0;
    localparam logic [4:0] CYC_RET_CC  = 5'd8;
    localparam logic [4:0] CYC_CALL    = 5'd12;
    localparam logic [4:0] CYC_PUSH    = 5'd16;
    localparam logic [4:0] CYC_POP     = 5'd12;
    localparam logic [4:0] CYC_RETI    = 5'd8;

    localparam logic [15:0] PC_STEP_SHORT = 16'd1;
    localparam logic [15:0] PC_STEP_CALL  = 16'd3;
    localparam logic [15:0] SP_STEP       = 16'd2;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_RET,
        KIND_CALL,
        KIND_PUSH,
        KIND_POP,
        KIND_RETI
    } kind_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_NZ,
        COND_Z,
        COND_NC,
        COND_C
    } cond_t;

    typedef struct packed {
        kind_t      kind;
        cond_t      cond;
        logic [4:0] cyc;
    } dec_t;

endpackage

// File: rtl/core/scru_instr_if.sv
// Instruction channel: valid/ready handshake with the instruction operands.
interface scru_instr_if;
    logic        valid;
    logic        ready;
    logic [4:0]  func;
    logic [15:0] pc_in;
    logic [15:0] sp_in;
    logic        flag_zero;
    logic        flag_carry;
    logic [15:0] push_word;
    logic [15:0] imm_target;
    logic [15:0] stack_word;

    modport source (
        output valid, func, pc_in, sp_in, flag_zero, flag_carry, push_word, imm_target,
               stack_word,
        input  ready
    );

    modport sink (
        input  valid, func, pc_in, sp_in, flag_zero, flag_carry, push_word, imm_target,
               stack_word,
        output ready
    );
endinterface

// File: rtl/core/scru_result_if.sv
// Result channel: valid/ready handshake with the instruction results.
interface scru_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] pc_out;
    logic [15:0] sp_out;
    logic        branch_taken;
    logic        pop_enable;
    logic [15:0] pop_word;
    logic        stack_write;
    logic [15:0] write_address;
    logic [15:0] write_word;
    logic [4:0]  cycles_added;
    logic        interrupts_on;

    modport source (
        output valid, pc_out, sp_out, branch_taken, pop_enable, pop_word, stack_write,
               write_address, write_word, cycles_added, interrupts_on,
        input  ready
    );

    modport sink (
        input  valid, pc_out, sp_out, branch_taken, pop_enable, pop_word, stack_write,
               write_address, write_word, cycles_added, interrupts_on,
        output ready
    );
endinterface

// File: rtl/core/scru_decode.sv
// Operation decoder: maps func to instruction kind, branch condition and cycle count.
module scru_decode (
    input  logic [4:0]    func,
    output scru_pkg::dec_t dec
);

    always_comb
    begin
        dec.kind = scru_pkg::KIND_NONE;
        dec.cond = scru_pkg::COND_ALWAYS;
        dec.cyc  = scru_pkg::CYC_NONE;
        case (func)
            scru_pkg::FUNC_RET_NZ:
            begin
                dec.kind = scru_pkg::KIND_RET;
                dec.cond = scru_pkg::COND_NZ;
                dec.cyc  = scru_pkg::CYC_RET_CC;
            end
            scru_pkg::FUNC_RET_Z:
            begin
                dec.kind = scru_pkg::KIND_RET;
                dec.cond = scru_pkg::COND_Z;
                dec.cyc  = scru_pkg::CYC_RET_CC;
            end
            scru_pkg::FUNC_RET_NC:
            begin
                dec.kind = scru_pkg::KIND_RET;
                dec.cond = scru_pkg::COND_NC;
                dec.cyc  = scru_pkg::CYC_RET_CC;
            end
            scru_pkg::FUNC_RET_C:
            begin
                dec.kind = scru_pkg::KIND_RET;
                dec.cond = scru_pkg::COND_C;
                dec.cyc  = scru_pkg::CYC_RET_CC;
            end
            scru_pkg::FUNC_RET:
            begin
                dec.kind = scru_pkg::KIND_RET;
            end
            scru_pkg::FUNC_CALL_NZ:
            begin
                dec.kind = scru_pkg::KIND_CALL;
                dec.cond = scru_pkg::COND_NZ;
                dec.cyc  = scru_pkg::CYC_CALL;
            end
            scru_pkg::FUNC_CALL_Z:
            begin
                dec.kind = scru_pkg::KIND_CALL;
                dec.cond = scru_pkg::COND_Z;
                dec.cyc  = scru_pkg::CYC_CALL;
            end
            scru_pkg::FUNC_CALL_NC:
            begin
                dec.kind = scru_pkg::KIND_CALL;
                dec.cond = scru_pkg::COND_NC;
                dec.cyc  = scru_pkg::CYC_CALL;
            end
            scru_pkg::FUNC_CALL_C:
            begin
                dec.kind = scru_pkg::KIND_CALL;
                dec.cond = scru_pkg::COND_C;
                dec.cyc  = scru_pkg::CYC_CALL;
            end
            scru_pkg::FUNC_CALL:
            begin
                dec.kind = scru_pkg::KIND_CALL;
                dec.cyc  = scru_pkg::CYC_CALL;
            end
            scru_pkg::FUNC_PUSH_BC, scru_pkg::FUNC_PUSH_DE,
            scru_pkg::FUNC_PUSH_HL, scru_pkg::FUNC_PUSH_AF:
            begin
                dec.kind = scru_pkg::KIND_PUSH;
                dec.cyc  = scru_pkg::CYC_PUSH;
            end
            scru_pkg::FUNC_POP_BC, scru_pkg::FUNC_POP_DE,
            scru_pkg::FUNC_POP_HL, scru_pkg::FUNC_POP_AF:
            begin
                dec.kind = scru_pkg::KIND_POP;
                dec.cyc  = scru_pkg::CYC_POP;
            end
            scru_pkg::FUNC_RETI:
            begin
                dec.kind = scru_pkg::KIND_RETI;
                dec.cyc  = scru_pkg::CYC_RETI;
            end
            default:
            begin
                dec.kind = scru_pkg::KIND_NONE;
            end
        endcase
    end

endmodule

// File: rtl/core/stack_call_return_unit.sv
// Stack call/return unit: three-stage pipeline (decode, condition/address add, result select).
// An instruction passes the decode, condition/address and output registers before its result is offered.
// Throughput: one instruction per cycle; the whole pipeline holds while a result waits.
// The last stage is the output register, so a stalled result holds its transfer.
// Reset clears the stage valid bits only; the data registers are not reset.
module stack_call_return_unit (
    input  logic         clk,
    input  logic         rst_n,
    scru_instr_if.sink   instr,
    scru_result_if.source result
);

    logic advance;

    // stage 1: decode
    logic            v1_reg;
    scru_pkg::dec_t  dec;
    scru_pkg::dec_t  dec1_reg;
    logic [15:0]     pc1_reg, sp1_reg, push1_reg, imm1_reg, stk1_reg;
    logic            z1_reg, c1_reg;

    // stage 2: condition and address arithmetic
    logic            v2_reg;
    logic            cond_ok;
    scru_pkg::kind_t kind2_reg;
    logic            ok2_reg;
    logic [4:0]      cyc2_reg;
    logic [15:0]     pc_short2_reg, pc_call2_reg, sp_up2_reg, sp_dn2_reg;
    logic [15:0]     push2_reg, imm2_reg, stk2_reg;

    // stage 3: output register
    logic            v3_reg;
    logic [15:0]     pc_out_reg, sp_out_reg, pop_word_reg, waddr_reg, wword_reg;
    logic            taken_reg, pen_reg, wen_reg, ime_reg;
    logic [4:0]      cyc3_reg;
    logic [15:0]     pc_out_next, sp_out_next, pop_word_next, waddr_next, wword_next;
    logic            taken_next, pen_next, wen_next, ime_next;

    assign advance     = !v3_reg || result.ready;
    assign instr.ready = advance;

    scru_decode u_decode (
        .func (instr.func),
        .dec  (dec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= instr.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dec1_reg  <= dec;
            pc1_reg   <= instr.pc_in;
            sp1_reg   <= instr.sp_in;
            z1_reg    <= instr.flag_zero;
            c1_reg    <= instr.flag_carry;
            push1_reg <= instr.push_word;
            imm1_reg  <= instr.imm_target;
            stk1_reg  <= instr.stack_word;
        end
    end

    always_comb
    begin
        case (dec1_reg.cond)
            scru_pkg::COND_ALWAYS: cond_ok = 1'b1;
            scru_pkg::COND_NZ:     cond_ok = !z1_reg;
            scru_pkg::COND_Z:      cond_ok = z1_reg;
            scru_pkg::COND_NC:     cond_ok = !c1_reg;
            scru_pkg::COND_C:      cond_ok = c1_reg;
            default:               cond_ok = 1'b1;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            kind2_reg     <= dec1_reg.kind;
            ok2_reg       <= cond_ok;
            cyc2_reg      <= dec1_reg.cyc;
            pc_short2_reg <= pc1_reg + scru_pkg::PC_STEP_SHORT;
            pc_call2_reg  <= pc1_reg + scru_pkg::PC_STEP_CALL;
            sp_up2_reg    <= sp1_reg + scru_pkg::SP_STEP;
            sp_dn2_reg    <= sp1_reg - scru_pkg::SP_STEP;
            push2_reg     <= push1_reg;
            imm2_reg      <= imm1_reg;
            stk2_reg      <= stk1_reg;
        end
    end

    always_comb
    begin
        pc_out_next   = pc_short2_reg;
        sp_out_next   = sp_up2_reg - scru_pkg::SP_STEP;
        taken_next    = 1'b0;
        pen_next      = 1'b0;
        pop_word_next = '0;
        wen_next      = 1'b0;
        waddr_next    = '0;
        wword_next    = '0;
        ime_next      = 1'b0;
        case (kind2_reg)
            scru_pkg::KIND_RET:
            begin
                if (ok2_reg)
                begin
                    pc_out_next = stk2_reg;
                    sp_out_next = sp_up2_reg;
                    taken_next  = 1'b1;
                end
            end
            scru_pkg::KIND_CALL:
            begin
                if (ok2_reg)
                begin
                    pc_out_next = imm2_reg;
                    sp_out_next = sp_dn2_reg;
                    taken_next  = 1'b1;
                    wen_next    = 1'b1;
                    waddr_next  = sp_dn2_reg;
                    wword_next  = pc_call2_reg;
                end
                else
                begin
                    pc_out_next = pc_call2_reg;
                end
            end
            scru_pkg::KIND_PUSH:
            begin
                sp_out_next = sp_dn2_reg;
                wen_next    = 1'b1;
                waddr_next  = sp_dn2_reg;
                wword_next  = push2_reg;
            end
            scru_pkg::KIND_POP:
            begin
                sp_out_next   = sp_up2_reg;
                pen_next      = 1'b1;
                pop_word_next = stk2_reg;
            end
            scru_pkg::KIND_RETI:
            begin
                pc_out_next = stk2_reg;
                sp_out_next = sp_up2_reg;
                taken_next  = 1'b1;
                ime_next    = 1'b1;
            end
            default:
            begin
                pc_out_next = pc_short2_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pc_out_reg   <= pc_out_next;
            sp_out_reg   <= sp_out_next;
            taken_reg    <= taken_next;
            pen_reg      <= pen_next;
            pop_word_reg <= pop_word_next;
            wen_reg      <= wen_next;
            waddr_reg    <= waddr_next;
            wword_reg    <= wword_next;
            cyc3_reg     <= cyc2_reg;
            ime_reg      <= ime_next;
        end
    end

    assign result.valid         = v3_reg;
    assign result.pc_out        = pc_out_reg;
    assign result.sp_out        = sp_out_reg;
    assign result.branch_taken  = taken_reg;
    assign result.pop_enable    = pen_reg;
    assign result.pop_word      = pop_word_reg;
    assign result.stack_write   = wen_reg;
    assign result.write_address = waddr_reg;
    assign result.write_word    = wword_reg;
    assign result.cycles_added  = cyc3_reg;
    assign result.interrupts_on = ime_reg;

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && advance) |=> v3_reg)
        else $error("stage 2 item lost on advance");

    a_write_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> !(wen_reg && pen_reg))
        else $error("stack write and pop in one result");

    a_write_at_sp: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && wen_reg) |-> (waddr_reg == sp_out_reg))
        else $error("stack write address differs from new SP");

    a_ime_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && ime_reg) |-> taken_reg)
        else $error("interrupt enable without return");

endmodule
